@@ rtl/rgbw_color_classifier_defines.svh @@
// Assertion macros for the RGBW color classifier.
// Included by the top level; expects clk and rst_n in scope.
`ifndef RGBW_COLOR_CLASSIFIER_DEFINES_SVH
`define RGBW_COLOR_CLASSIFIER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define RGBW_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define RGBW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rgbw_pkg.sv @@
// Shared types and constants for the RGBW color classifier.
// No dependencies; used by every other file of the block but the assertion macros.
package rgbw_pkg;

    // Default right shift applied after the gain multiply (Q10 gains)
    localparam int unsigned GAIN_SHIFT_DEF = 10;

    // Field widths
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned LIM_W   = 12;
    localparam int unsigned PROD_W  = 32;
    localparam int unsigned SUM_W   = CNT_W + 2;
    localparam int unsigned NUM_W   = CNT_W + 12;
    localparam int unsigned AXIS_W  = CNT_W + 3;
    localparam int unsigned MAG_W   = AXIS_W - 1;
    localparam int unsigned THR_W   = LIM_W + 1;
    localparam int unsigned SPROD_W = SUM_W + THR_W;
    localparam int unsigned CLS_W   = 3;

    // Inverse saturation scale (3 * 1024)
    localparam int unsigned INV_SAT_SCALE = 3072;

    // APB register file
    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned IDX_W  = ADDR_W - 2;

    localparam logic [IDX_W-1:0] REG_SENSOR_PRESENT = 3'd0;
    localparam logic [IDX_W-1:0] REG_WHITE_THRESH   = 3'd1;
    localparam logic [IDX_W-1:0] REG_RED_GAIN       = 3'd2;
    localparam logic [IDX_W-1:0] REG_GREEN_GAIN     = 3'd3;
    localparam logic [IDX_W-1:0] REG_BLUE_GAIN      = 3'd4;
    localparam logic [IDX_W-1:0] REG_SAT_LIMIT      = 3'd5;

    // Color class codes
    localparam logic [CLS_W-1:0] CLS_BLACK   = 3'd0;
    localparam logic [CLS_W-1:0] CLS_WHITE   = 3'd1;
    localparam logic [CLS_W-1:0] CLS_RED     = 3'd2;
    localparam logic [CLS_W-1:0] CLS_YELLOW  = 3'd3;
    localparam logic [CLS_W-1:0] CLS_GREEN   = 3'd4;
    localparam logic [CLS_W-1:0] CLS_CYAN    = 3'd5;
    localparam logic [CLS_W-1:0] CLS_BLUE    = 3'd6;
    localparam logic [CLS_W-1:0] CLS_MAGENTA = 3'd7;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic              sensor_present;
        logic [CNT_W-1:0]  white_threshold;
        logic [GAIN_W-1:0] red_gain;
        logic [GAIN_W-1:0] green_gain;
        logic [GAIN_W-1:0] blue_gain;
        logic [LIM_W-1:0]  saturation_limit;
    } cfg_t;

    // Stage 1 to stage 2: scaled colors
    typedef struct packed {
        logic             black;
        logic [CNT_W-1:0] sr;
        logic [CNT_W-1:0] sg;
        logic [CNT_W-1:0] sb;
    } scaled_t;

    // Stage 2 to stage 3: saturation terms and hue axes
    typedef struct packed {
        logic                     black;
        logic                     sum_nz;
        logic [SUM_W-1:0]         sum;
        logic [NUM_W-1:0]         num;
        logic signed [AXIS_W-1:0] hx;
        logic signed [AXIS_W-1:0] hy;
    } axis_t;

endpackage

@@ rtl/rgbw_sample_if.sv @@
// Input channel carrying one RGBW reading per transaction.
// Depends on rgbw_pkg for field widths.
interface rgbw_sample_if;
    logic                       valid;
    logic                       ready;
    logic [rgbw_pkg::CNT_W-1:0] white_count;
    logic [rgbw_pkg::CNT_W-1:0] red_count;
    logic [rgbw_pkg::CNT_W-1:0] green_count;
    logic [rgbw_pkg::CNT_W-1:0] blue_count;

    modport source (output valid, white_count, red_count, green_count, blue_count,
                    input ready);
    modport sink (input valid, white_count, red_count, green_count, blue_count,
                  output ready);
endinterface

@@ rtl/rgbw_class_if.sv @@
// Output channel carrying one color class per transaction.
// Depends on rgbw_pkg for the class width.
interface rgbw_class_if;
    logic                       valid;
    logic                       ready;
    logic [rgbw_pkg::CLS_W-1:0] color_class;

    modport source (output valid, color_class, input ready);
    modport sink (input valid, color_class, output ready);
endinterface

@@ rtl/rgbw_color_classifier.sv @@
// Top level of the RGBW color classifier: config registers and pipeline.
// Depends on rgbw_pkg, the channel interfaces, the stage modules and
// rgbw_color_classifier_defines.svh.
//
// Usage:
//   sample carries one reading (white, red, green, blue counts) per
//   transaction; result returns one color class for each reading, in order.
//   Both use valid/ready; a transaction moves when both are high.
//   The APB port sets presence, white threshold, three gains and the
//   saturation limit; write it only while no reading is in flight.
// Timing:
//   Four register stages (gain multiply, sum/axes, threshold multiply and
//   hue, compare and output). One reading is accepted every cycle while
//   result is taken.
// Reset:
//   rst_n clears all stage valid bits and loads the register defaults.
// Stall:
//   Each stage holds while the one after it is full and stalled; empty
//   stages keep filling, so up to four readings sit in the pipe before
//   sample.ready drops. Nothing is dropped or repeated.
`include "rgbw_color_classifier_defines.svh"

module rgbw_color_classifier #(
    parameter int unsigned GAIN_SHIFT = rgbw_pkg::GAIN_SHIFT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    rgbw_sample_if.sink                 sample,
    rgbw_class_if.source                result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rgbw_pkg::ADDR_W-1:0] paddr,
    input  logic [rgbw_pkg::DATA_W-1:0] pwdata,
    output logic [rgbw_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import rgbw_pkg::*;

    cfg_t    cfg;
    scaled_t s1_data;
    axis_t   s2_data;
    logic    s1_valid;
    logic    s1_ready;
    logic    s2_valid;
    logic    s2_ready;
    logic    full_stall;
    logic    s1_moves;

    // Configuration registers
    rgbw_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage 1: gains and black test
    rgbw_scale_stage #(
        .GAIN_SHIFT (GAIN_SHIFT)
    ) u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (sample.valid),
        .in_ready    (sample.ready),
        .white_count (sample.white_count),
        .red_count   (sample.red_count),
        .green_count (sample.green_count),
        .blue_count  (sample.blue_count),
        .cfg         (cfg),
        .out_valid   (s1_valid),
        .out_ready   (s1_ready),
        .out_data    (s1_data)
    );

    // Stage 2: min, sum, axes
    rgbw_axis_stage u_axis (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // Stages 3 and 4: threshold, hue, output register
    rgbw_class_stage u_class (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s2_valid),
        .in_ready         (s2_ready),
        .in_data          (s2_data),
        .saturation_limit (cfg.saturation_limit),
        .out_valid        (result.valid),
        .out_ready        (result.ready),
        .color_class      (result.color_class)
    );

    // Every stage full with the output stalled; stage 1 handing its item on
    assign full_stall = result.valid && !result.ready && s1_valid && s2_valid && !s2_ready;
    assign s1_moves   = s1_valid && s1_ready;

    // An empty output stage always lets a new reading in
    `RGBW_ASSERT_SAME(a_empty_accepts, !result.valid, sample.ready, "input blocked, output empty")

    // Backpressure only stops intake once every stage is full
    `RGBW_ASSERT_SAME(a_full_stalls, full_stall, !sample.ready, "input open with full pipeline")

    // A stage that holds an item with a free successor must move
    `RGBW_ASSERT_NEXT(a_stage_moves, s1_moves, s2_valid, "stage 1 item lost")

endmodule

@@ rtl/rgbw_cfg_regs.sv @@
// APB configuration registers for the RGBW color classifier.
// Depends on rgbw_pkg for the register map and cfg_t.
module rgbw_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rgbw_pkg::ADDR_W-1:0] paddr,
    input  logic [rgbw_pkg::DATA_W-1:0] pwdata,
    output logic [rgbw_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output rgbw_pkg::cfg_t              cfg
);
    import rgbw_pkg::*;

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Decode the write into the addressed field
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_SENSOR_PRESENT: cfg_next.sensor_present   = pwdata[0];
                REG_WHITE_THRESH:   cfg_next.white_threshold  = pwdata[CNT_W-1:0];
                REG_RED_GAIN:       cfg_next.red_gain         = pwdata[GAIN_W-1:0];
                REG_GREEN_GAIN:     cfg_next.green_gain       = pwdata[GAIN_W-1:0];
                REG_BLUE_GAIN:      cfg_next.blue_gain        = pwdata[GAIN_W-1:0];
                REG_SAT_LIMIT:      cfg_next.saturation_limit = pwdata[LIM_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers; reset to unity gains and default limits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensor_present   <= 1'b1;
            cfg_reg.white_threshold  <= '0;
            cfg_reg.red_gain         <= GAIN_W'(1024);
            cfg_reg.green_gain       <= GAIN_W'(1024);
            cfg_reg.blue_gain        <= GAIN_W'(1024);
            cfg_reg.saturation_limit <= LIM_W'(512);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (idx)
            REG_SENSOR_PRESENT: prdata = DATA_W'(cfg_reg.sensor_present);
            REG_WHITE_THRESH:   prdata = DATA_W'(cfg_reg.white_threshold);
            REG_RED_GAIN:       prdata = DATA_W'(cfg_reg.red_gain);
            REG_GREEN_GAIN:     prdata = DATA_W'(cfg_reg.green_gain);
            REG_BLUE_GAIN:      prdata = DATA_W'(cfg_reg.blue_gain);
            REG_SAT_LIMIT:      prdata = DATA_W'(cfg_reg.saturation_limit);
            default:            prdata = '0;
        endcase
    end

endmodule

@@ rtl/rgbw_scale_stage.sv @@
// Pipeline stage 1: gain multiply per color and the black test.
// Depends on rgbw_pkg for cfg_t and scaled_t.
module rgbw_scale_stage #(
    parameter int unsigned GAIN_SHIFT = rgbw_pkg::GAIN_SHIFT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [rgbw_pkg::CNT_W-1:0] white_count,
    input  logic [rgbw_pkg::CNT_W-1:0] red_count,
    input  logic [rgbw_pkg::CNT_W-1:0] green_count,
    input  logic [rgbw_pkg::CNT_W-1:0] blue_count,
    input  rgbw_pkg::cfg_t             cfg,
    output logic                       out_valid,
    input  logic                       out_ready,
    output rgbw_pkg::scaled_t          out_data
);
    import rgbw_pkg::*;

    logic              valid_reg;
    scaled_t           data_reg;
    scaled_t           data_next;
    logic [PROD_W-1:0] prod_r;
    logic [PROD_W-1:0] prod_g;
    logic [PROD_W-1:0] prod_b;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Full 32-bit products, shifted down then wrapped to 16 bits
    always_comb
    begin
        prod_r = PROD_W'(red_count) * PROD_W'(cfg.red_gain);
        prod_g = PROD_W'(green_count) * PROD_W'(cfg.green_gain);
        prod_b = PROD_W'(blue_count) * PROD_W'(cfg.blue_gain);
        data_next.sr    = CNT_W'(prod_r >> GAIN_SHIFT);
        data_next.sg    = CNT_W'(prod_g >> GAIN_SHIFT);
        data_next.sb    = CNT_W'(prod_b >> GAIN_SHIFT);
        data_next.black = !cfg.sensor_present || (white_count < cfg.white_threshold);
    end

    // Advance the valid bit whenever the stage can move
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Load payload on an accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/rgbw_axis_stage.sv @@
// Pipeline stage 2: minimum, color sum, saturation numerator, hue axes.
// Depends on rgbw_pkg for scaled_t and axis_t.
module rgbw_axis_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rgbw_pkg::scaled_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rgbw_pkg::axis_t   out_data
);
    import rgbw_pkg::*;

    logic              valid_reg;
    axis_t             data_reg;
    axis_t             data_next;
    logic [CNT_W-1:0]  mn;
    logic [AXIS_W-1:0] gb_diff;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Form the saturation terms and the two hue axes
    always_comb
    begin
        mn = in_data.sr;
        if (in_data.sg < mn)
        begin
            mn = in_data.sg;
        end
        if (in_data.sb < mn)
        begin
            mn = in_data.sb;
        end
        data_next.black  = in_data.black;
        data_next.sum    = SUM_W'(in_data.sr) + SUM_W'(in_data.sg) + SUM_W'(in_data.sb);
        data_next.sum_nz = (data_next.sum != '0);
        data_next.num    = NUM_W'(mn) * NUM_W'(INV_SAT_SCALE);
        // X = 2R - G - B, Y = 3(G - B)
        data_next.hx = $signed(AXIS_W'({in_data.sr, 1'b0}) - AXIS_W'(in_data.sg)
                       - AXIS_W'(in_data.sb));
        gb_diff      = AXIS_W'(in_data.sg) - AXIS_W'(in_data.sb);
        data_next.hy = $signed(gb_diff + {gb_diff[AXIS_W-2:0], 1'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/rgbw_class_stage.sv @@
// Pipeline stages 3 and 4: hue pick, saturation threshold, final class.
// Depends on rgbw_pkg for axis_t, cfg_t and class codes.
module rgbw_class_stage (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  rgbw_pkg::axis_t            in_data,
    input  logic [rgbw_pkg::LIM_W-1:0] saturation_limit,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rgbw_pkg::CLS_W-1:0] color_class
);
    import rgbw_pkg::*;

    // Stage 3 registers
    logic               v3_reg;
    logic               black3_reg;
    logic               sum_nz3_reg;
    logic [NUM_W-1:0]   num3_reg;
    logic [SPROD_W-1:0] thr3_reg;
    logic [CLS_W-1:0]   hue3_reg;
    logic [SPROD_W-1:0] thr3_next;
    logic [CLS_W-1:0]   hue3_next;
    logic [MAG_W-1:0]   mag_x;
    logic [MAG_W-1:0]   mag_y;
    logic               rdy3;

    // Stage 4 (output) registers
    logic               v4_reg;
    logic [CLS_W-1:0]   cls4_reg;
    logic [CLS_W-1:0]   cls4_next;
    logic               rdy4;
    logic               is_white;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign in_ready = rdy3;

    assign out_valid   = v4_reg;
    assign color_class = cls4_reg;

    // Hue from axis magnitudes and signs; threshold (limit + 1) * sum
    always_comb
    begin
        mag_x = in_data.hx[AXIS_W-1] ? MAG_W'(-in_data.hx) : MAG_W'(in_data.hx);
        mag_y = in_data.hy[AXIS_W-1] ? MAG_W'(-in_data.hy) : MAG_W'(in_data.hy);
        if (mag_x > mag_y)
        begin
            hue3_next = in_data.hx[AXIS_W-1] ? CLS_CYAN : CLS_RED;
        end
        else if (in_data.hx[AXIS_W-1])
        begin
            hue3_next = in_data.hy[AXIS_W-1] ? CLS_BLUE : CLS_GREEN;
        end
        else
        begin
            hue3_next = in_data.hy[AXIS_W-1] ? CLS_MAGENTA : CLS_YELLOW;
        end
        thr3_next = SPROD_W'(in_data.sum) * SPROD_W'(THR_W'(saturation_limit) + THR_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (rdy3)
        begin
            v3_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy3)
        begin
            black3_reg  <= in_data.black;
            sum_nz3_reg <= in_data.sum_nz;
            num3_reg    <= in_data.num;
            thr3_reg    <= thr3_next;
            hue3_reg    <= hue3_next;
        end
    end

    // Quotient exceeds the limit exactly when num >= (limit + 1) * sum
    always_comb
    begin
        is_white = sum_nz3_reg && (SPROD_W'(num3_reg) >= thr3_reg);
        if (black3_reg)
        begin
            cls4_next = CLS_BLACK;
        end
        else if (is_white)
        begin
            cls4_next = CLS_WHITE;
        end
        else
        begin
            cls4_next = hue3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (rdy4)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v3_reg && rdy4)
        begin
            cls4_reg <= cls4_next;
        end
    end

endmodule

@@ tb/rgbw_color_classifier_test.sv @@
// Self-checking testbench for the RGBW color classifier: scoreboard class and top module.
// Depends on rgbw_pkg, rgbw_sample_if, rgbw_class_if and rgbw_color_classifier.
// Registers are written over APB; readings and class results move over valid/ready channels.
`timescale 1ns / 1ps

// Predict the class of each accepted reading and check results in order
class color_scoreboard;
    rgbw_pkg::cfg_t                 cfg;
    logic [rgbw_pkg::CLS_W-1:0]     expected_classes[$];
    int                             errors;
    int                             readings;
    int                             class_hits[8];

    function new();
        cfg.sensor_present   = 1'b1;
        cfg.white_threshold  = '0;
        cfg.red_gain         = 16'd1024;
        cfg.green_gain       = 16'd1024;
        cfg.blue_gain        = 16'd1024;
        cfg.saturation_limit = 12'd512;
        errors   = 0;
        readings = 0;
        foreach (class_hits[i])
            class_hits[i] = 0;
    endfunction

    // Mirror a register write; unmapped indexes leave the copy untouched
    function void write_register(logic [rgbw_pkg::IDX_W-1:0] idx, logic [31:0] value);
        case (idx)
            rgbw_pkg::REG_SENSOR_PRESENT: cfg.sensor_present   = value[0];
            rgbw_pkg::REG_WHITE_THRESH:   cfg.white_threshold  = value[15:0];
            rgbw_pkg::REG_RED_GAIN:       cfg.red_gain         = value[15:0];
            rgbw_pkg::REG_GREEN_GAIN:     cfg.green_gain       = value[15:0];
            rgbw_pkg::REG_BLUE_GAIN:      cfg.blue_gain        = value[15:0];
            rgbw_pkg::REG_SAT_LIMIT:      cfg.saturation_limit = value[11:0];
            default: ;
        endcase
    endfunction

    // Full 32-bit product, shift out the Q10 fraction, wrap to 16 bits
    function logic [15:0] scale_count(logic [15:0] count, logic [15:0] gain);
        logic [31:0] prod;
        prod = {16'b0, count} * {16'b0, gain};
        return 16'(prod >> rgbw_pkg::GAIN_SHIFT_DEF);
    endfunction

    function logic [rgbw_pkg::CLS_W-1:0] classify_reading(logic [15:0] w, logic [15:0] r,
                                                          logic [15:0] g, logic [15:0] b);
        logic [15:0] sr;
        logic [15:0] sg;
        logic [15:0] sb;
        logic [15:0] mn;
        int unsigned sum;
        int unsigned inv_sat;
        int          hx;
        int          hy;
        int          ax;
        int          ay;
        if (!cfg.sensor_present || w < cfg.white_threshold)
            return rgbw_pkg::CLS_BLACK;
        sr = scale_count(r, cfg.red_gain);
        sg = scale_count(g, cfg.green_gain);
        sb = scale_count(b, cfg.blue_gain);
        mn = sr;
        if (sg < mn)
            mn = sg;
        if (sb < mn)
            mn = sb;
        sum = int'(sr) + int'(sg) + int'(sb);
        // A zero sum counts as full saturation
        inv_sat = (sum == 0) ? 0 : (rgbw_pkg::INV_SAT_SCALE * int'(mn)) / sum;
        if (inv_sat > cfg.saturation_limit)
            return rgbw_pkg::CLS_WHITE;
        hx = 2 * int'(sr) - int'(sg) - int'(sb);
        hy = 3 * (int'(sg) - int'(sb));
        ax = (hx < 0) ? -hx : hx;
        ay = (hy < 0) ? -hy : hy;
        // Equal magnitudes fall through to the quadrant choice
        if (ax > ay)
            return (hx < 0) ? rgbw_pkg::CLS_CYAN : rgbw_pkg::CLS_RED;
        if (hx < 0)
            return (hy < 0) ? rgbw_pkg::CLS_BLUE : rgbw_pkg::CLS_GREEN;
        return (hy < 0) ? rgbw_pkg::CLS_MAGENTA : rgbw_pkg::CLS_YELLOW;
    endfunction

    function void note_reading(logic [15:0] w, logic [15:0] r, logic [15:0] g, logic [15:0] b);
        logic [rgbw_pkg::CLS_W-1:0] cls;
        cls = classify_reading(w, r, g, b);
        expected_classes.push_back(cls);
        class_hits[cls]++;
        readings++;
    endfunction

    function void check_class(logic [rgbw_pkg::CLS_W-1:0] actual);
        logic [rgbw_pkg::CLS_W-1:0] want;
        if (expected_classes.size() == 0)
        begin
            errors++;
            $error("color_class: expected no transaction, actual %0d", actual);
            return;
        end
        want = expected_classes.pop_front();
        if (actual !== want)
        begin
            errors++;
            $error("color_class: expected %0d, actual %0d", want, actual);
        end
    endfunction

    function int pending();
        return expected_classes.size();
    endfunction
endclass

module rgbw_color_classifier_test;
    import rgbw_pkg::*;

    localparam int RUN_LIMIT   = 200000;
    localparam int LONG_STALL  = 60;
    localparam int DRAIN_TAIL  = 8;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 50;

    // Index with no register behind it; writes there must be ignored
    localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd7;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    rgbw_sample_if sample_bus();
    rgbw_class_if  class_bus();

    color_scoreboard sb;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int          stall_requests;
    int          stall_seen;
    int          stall_left;
    int          cycle_count;
    int          setting_count;

    rgbw_color_classifier u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_bus),
        .result  (class_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Abort the run if it hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Check each result transaction, then drive ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && class_bus.valid && class_bus.ready)
            sb.check_class(class_bus.color_class);
        if (stall_seen != stall_requests)
        begin
            stall_seen = stall_requests;
            stall_left = LONG_STALL;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            class_bus.ready <= 1'b0;
        end
        else
            class_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // APB write with setup and access phases, then idle; the scoreboard copy follows on completion
    task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_register(idx, value);
        @(posedge clk);
    endtask

    // Offer one reading, idling at random first, and hold it until taken
    task automatic send_reading(input logic [15:0] w, input logic [15:0] r,
                                input logic [15:0] g, input logic [15:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_bus.valid <= 1'b0;
            @(posedge clk);
        end
        sample_bus.valid       <= 1'b1;
        sample_bus.white_count <= w;
        sample_bus.red_count   <= r;
        sample_bus.green_count <= g;
        sample_bus.blue_count  <= b;
        do @(posedge clk); while (!sample_bus.ready);
        sb.note_reading(w, r, g, b);
    endtask

    // Drop valid and hold until every predicted class has come back
    task automatic drain();
        sample_bus.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'(768 + $urandom_range(511));
            default: return 16'($urandom);
        endcase
    endfunction

    // Random register setting with the extremes drawn now and then
    task automatic program_setting();
        logic [15:0] thr;
        logic [11:0] lim;
        case ($urandom_range(5))
            0:       thr = 16'h0000;
            1:       thr = 16'hFFFF;
            2:       thr = 16'($urandom);
            default: thr = 16'($urandom_range(2000));
        endcase
        case ($urandom_range(5))
            0:       lim = 12'h000;
            1:       lim = 12'hFFF;
            2:       lim = 12'($urandom);
            default: lim = 12'(300 + $urandom_range(700));
        endcase
        drain();
        apb_write(REG_SENSOR_PRESENT, {31'b0, ($urandom_range(9) != 0)});
        apb_write(REG_WHITE_THRESH, {16'b0, thr});
        apb_write(REG_RED_GAIN, {16'b0, pick_gain()});
        apb_write(REG_GREEN_GAIN, {16'b0, pick_gain()});
        apb_write(REG_BLUE_GAIN, {16'b0, pick_gain()});
        apb_write(REG_SAT_LIMIT, {20'b0, lim});
        setting_count++;
    endtask

    // Mix raw noise with gray, dim and hue-leaning readings; white is random or sits near the threshold
    task automatic random_reading();
        logic [15:0] w;
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic [15:0] base;
        logic [2:0]  bright;
        int          thr;
        int          kind;
        thr  = sb.cfg.white_threshold;
        kind = $urandom_range(9);
        if (kind < 2)
        begin
            r = 16'($urandom);
            g = 16'($urandom);
            b = 16'($urandom);
        end
        else if (kind == 2)
        begin
            base = 16'($urandom);
            r = base ^ 16'($urandom_range(63));
            g = base ^ 16'($urandom_range(63));
            b = base ^ 16'($urandom_range(63));
        end
        else if (kind == 3)
        begin
            r = 16'($urandom_range(15));
            g = 16'($urandom_range(15));
            b = 16'($urandom_range(15));
        end
        else
        begin
            // One or two strong channels over weak ones
            bright = 3'($urandom_range(1, 6));
            r = bright[0] ? 16'($urandom_range(20000, 65535)) : 16'($urandom_range(5000));
            g = bright[1] ? 16'($urandom_range(20000, 65535)) : 16'($urandom_range(5000));
            b = bright[2] ? 16'($urandom_range(20000, 65535)) : 16'($urandom_range(5000));
        end
        case ($urandom_range(2))
            0:       w = 16'($urandom);
            1:       w = (thr == 0) ? 16'h0000 : 16'(thr - 1);
            default: w = 16'((thr + $urandom_range(300) > 65535) ? 65535
                                                                  : thr + $urandom_range(300));
        endcase
        send_reading(w, r, g, b);
    endtask

    initial
    begin
        sb = new();
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        sample_bus.valid       = 1'b0;
        sample_bus.white_count = '0;
        sample_bus.red_count   = '0;
        sample_bus.green_count = '0;
        sample_bus.blue_count  = '0;
        class_bus.ready        = 1'b0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        stall_requests = 0;
        stall_seen     = 0;
        stall_left     = 0;
        cycle_count    = 0;
        setting_count  = 1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: zero sum, full scale, each hue, axis ties, saturation edge
        send_reading(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_reading(16'd1000, 16'hFFFF, 16'h0000, 16'h0000);
        send_reading(16'd1000, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_reading(16'd1000, 16'h0000, 16'h0000, 16'hFFFF);
        send_reading(16'd1000, 16'h0000, 16'hFFFF, 16'h0000);
        send_reading(16'd1000, 16'd40000, 16'h0000, 16'd40000);
        send_reading(16'd1000, 16'd40000, 16'd40000, 16'h0000);
        send_reading(16'd5, 16'd2, 16'd1, 16'd0);
        send_reading(16'd5, 16'd0, 16'd1, 16'd2);
        send_reading(16'd5, 16'd100, 16'd100, 16'd400);
        send_reading(16'd5, 16'd100, 16'd100, 16'd398);

        // Sensor absent: everything is black
        drain();
        apb_write(REG_SENSOR_PRESENT, 32'd0);
        setting_count++;
        send_reading(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        send_reading(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);

        // White count on both sides of the threshold
        drain();
        apb_write(REG_SENSOR_PRESENT, 32'd1);
        apb_write(REG_WHITE_THRESH, 32'h8000);
        setting_count++;
        send_reading(16'h7FFF, 16'hFFFF, 16'h0000, 16'h0000);
        send_reading(16'h8000, 16'hFFFF, 16'h0000, 16'h0000);
        drain();
        apb_write(REG_WHITE_THRESH, 32'hFFFF);
        setting_count++;
        send_reading(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        send_reading(16'hFFFE, 16'h0000, 16'hFFFF, 16'h0000);

        // Largest gains wrap the scaled colors; widest saturation limit
        drain();
        apb_write(REG_WHITE_THRESH, 32'd0);
        apb_write(REG_RED_GAIN, 32'hFFFF);
        apb_write(REG_GREEN_GAIN, 32'hFFFF);
        apb_write(REG_BLUE_GAIN, 32'hFFFF);
        apb_write(REG_SAT_LIMIT, 32'hFFF);
        setting_count++;
        send_reading(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_reading(16'd1, 16'hFFFF, 16'h1234, 16'h0000);

        // Zero gains force a zero sum; an unmapped write changes nothing
        drain();
        apb_write(REG_RED_GAIN, 32'd0);
        apb_write(REG_GREEN_GAIN, 32'd0);
        apb_write(REG_BLUE_GAIN, 32'd0);
        apb_write(REG_SAT_LIMIT, 32'd0);
        apb_write(REG_UNMAPPED, 32'hFFFF_FFFF);
        setting_count++;
        send_reading(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain();
        apb_write(REG_RED_GAIN, 32'd1024);
        apb_write(REG_GREEN_GAIN, 32'd1024);
        apb_write(REG_BLUE_GAIN, 32'd1024);
        setting_count++;
        send_reading(16'd1, 16'd100, 16'd100, 16'd100);

        // Random phases: sender-light, receiver-light, then no idling
        for (int phase = 0; phase < PHASES; phase++)
        begin
            program_setting();
            case (phase / 3)
                0:
                begin
                    send_idle_pct = 12;
                    recv_idle_pct = 47;
                end
                1:
                begin
                    send_idle_pct = 47;
                    recv_idle_pct = 12;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // Back up the pipe while the sender keeps offering
            if (phase == 6)
                stall_requests++;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (phase == 4 && i == PHASE_ITEMS / 2)
                    drain();
                random_reading();
            end
        end

        drain();
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("Checked %0d readings across %0d register settings, idle and stall mixes",
                 sb.readings, setting_count);
        $display("Classes black/white/red/yellow/green/cyan/blue/magenta: %0d %0d %0d %0d %0d %0d %0d %0d",
                 sb.class_hits[0], sb.class_hits[1], sb.class_hits[2], sb.class_hits[3],
                 sb.class_hits[4], sb.class_hits[5], sb.class_hits[6], sb.class_hits[7]);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
